>>> sv/ssirack_pkg.sv
// Shared constants and helpers for the SSI encoder rack position reader.
package ssirack_pkg;

  localparam int POSITION_BITS = 12;
  localparam int FRAME_BITS    = POSITION_BITS + 2;
  localparam int COUNT_W       = $clog2(FRAME_BITS + 1);
  localparam int READING_W     = 12;
  localparam int OFFSET_W      = 14;

  localparam logic [READING_W-1:0] WRAP_COUNT  = 12'd4095;
  localparam logic [READING_W-1:0] MIN_RESET   = 12'd0;
  localparam logic [READING_W-1:0] MAX_RESET   = 12'd4095;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_READING = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_READING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCKWISE   = 2'd2;

  typedef logic signed [OFFSET_W-1:0] offset_t;

  // Halve a signed value, truncating toward zero
  function automatic offset_t half_trunc(input offset_t v);
    offset_t adj;
    adj = v + (v[OFFSET_W-1] ? offset_t'(1) : offset_t'(0));
    return adj >>> 1;
  endfunction

endpackage

>>> sv/ssi_encoder_rack_position.sv
// SSI encoder frame reader: check bits, position and rack offset.
// Throughput: one serial bit transfer per cycle, sustained under no backpressure.
// After the transfer of its last bit, a frame's result passes through the frame
// register and then the result register before it reaches the output.
// Reset (rst_n low, synchronous) clears the bit count, shift register and
// pipeline valids, and returns the configuration registers to their defaults.
module ssi_encoder_rack_position (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [ssirack_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssirack_pkg::READING_W-1:0]   cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] sdo_bit
  input  logic [0:0]  in_tuser,   // [0] frame_start
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] position, [25:12] rack_offset
  output logic [0:0]  out_tuser   // [0] position_valid
);
  import ssirack_pkg::*;

  logic [READING_W-1:0]  min_reading_r;
  logic [READING_W-1:0]  max_reading_r;
  logic                  clockwise_r;

  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt, count_inc;
  logic                  frame_done;

  logic                  frame_valid_r;
  logic [FRAME_BITS-1:0] frame_r;

  logic                  out_valid_r;
  logic [READING_W-1:0]  position_r;
  logic                  pos_ok_r;
  offset_t               offset_r;

  logic                  out_free;
  logic                  frame_adv;
  logic                  in_xfer;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_reading_r <= MIN_RESET;
      max_reading_r <= MAX_RESET;
      clockwise_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_READING: min_reading_r <= cfg_wdata;
        REG_MAX_READING: max_reading_r <= cfg_wdata;
        REG_CLOCKWISE:   clockwise_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign frame_adv = !frame_valid_r || out_free;
  assign in_tready = frame_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // shift in one bit; a start mark restarts the count
  always_comb begin
    count_inc  = (in_tuser[0] ? '0 : count_r) + COUNT_W'(1);
    frame_done = (count_inc == COUNT_W'(FRAME_BITS));
    count_nxt  = frame_done ? '0 : count_inc;
    shift_nxt  = {shift_r[FRAME_BITS-2:0], in_tdata[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      count_r <= '0;
    end else if (in_xfer) begin
      shift_r <= shift_nxt;
      count_r <= count_nxt;
    end
  end

  // frame register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
    end else if (frame_adv) begin
      frame_valid_r <= in_xfer && frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && frame_done && frame_adv) begin
      frame_r <= shift_nxt;
    end
  end

  // check bits and offset
  logic                 odd_par, even_par, chk_ok;
  logic [READING_W-1:0] pos_low;
  offset_t              pos_s, mn_s, mx_s, sp, off;
  logic                 mn_gt_mx;

  always_comb begin
    odd_par  = 1'b0;
    even_par = 1'b0;
    for (int i = 0; i < POSITION_BITS; i++) begin
      if (i % 2 == 1) odd_par  = odd_par  ^ frame_r[i];
      else            even_par = even_par ^ frame_r[i];
    end
    chk_ok = (frame_r[POSITION_BITS+1] == !odd_par) &&
             (frame_r[POSITION_BITS]   == !even_par);

    pos_low  = frame_r[READING_W-1:0];
    pos_s    = offset_t'({1'b0, pos_low});
    mn_s     = offset_t'({1'b0, min_reading_r});
    mx_s     = offset_t'({1'b0, max_reading_r});
    mn_gt_mx = (min_reading_r > max_reading_r);

    if (clockwise_r) begin
      sp = mn_gt_mx ? half_trunc(mn_s - mx_s)
                    : half_trunc(mx_s - offset_t'(WRAP_COUNT) + mn_s);
      if (max_reading_r > min_reading_r) off = pos_s - mn_s;
      else if (pos_s < sp)              off = offset_t'(WRAP_COUNT) - mn_s + pos_s;
      else                               off = pos_s - mn_s;
    end else begin
      sp = mn_gt_mx ? half_trunc(mx_s - offset_t'(WRAP_COUNT) + mn_s)
                    : half_trunc(mx_s + mn_s);
      if (mn_gt_mx)         off = mn_s - pos_s;
      else if (pos_s < sp)  off = mn_s - pos_s;
      else                  off = mn_s + offset_t'(WRAP_COUNT) - pos_s;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= frame_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && frame_valid_r) begin
      position_r <= pos_low;
      pos_ok_r   <= chk_ok;
      offset_r   <= chk_ok ? off : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, offset_r, position_r};
  assign out_tuser  = pos_ok_r;

  // assertions
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < COUNT_W'(FRAME_BITS))
    else $error("bit count out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pos_ok_r |-> offset_r == '0)
    else $error("offset nonzero on invalid frame");

  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid_r && !out_free |=> frame_valid_r && $stable(frame_r))
    else $error("pending frame lost under stall");

  a_frame_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && frame_done |=> frame_valid_r)
    else $error("completed frame not captured");

endmodule
